@@ rtl/core/edh_pkg.sv @@
package edh_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int GRAY_W    = 8;
  localparam int LW_W      = 11;
  localparam int ERR_W     = 11;
  localparam int EXT_W     = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
  localparam int OQ_DEPTH  = 3;
  localparam int OQ_CNT_W  = 2;
  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = LW_W'(512);

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  col;
    logic              last;
    logic              first_row;
    logic              frame_start;
    logic [GRAY_W-1:0] gray;
  } pix_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    err_t             data;
  } wr_t;

  function automatic err_t sat11(input logic signed [12:0] v);
    if (v > 13'sd1023) begin
      return 11'sh3ff;
    end else if (v < -13'sd1024) begin
      return 11'sh400;
    end
    return v[10:0];
  endfunction

  // divide by 16, truncating toward zero
  function automatic logic signed [11:0] div16(input logic signed [15:0] p);
    logic signed [15:0] t;
    t = p[15] ? p + 16'sd15 : p;
    return t[15:4];
  endfunction

endpackage

@@ rtl/core/edh_line_buffer.sv @@
module edh_line_buffer
  import edh_pkg::*;
(
  input  logic             clk,
  input  wr_t              wr,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output err_t             rd_data
);

  err_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/edh_scan.sv @@
module edh_scan
  import edh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [GRAY_W-1:0] gray,
  input  logic              frame_start,
  input  logic [COL_W-1:0]  last_col,
  output logic [COL_W-1:0]  rd_addr,
  output pix_t              pix
);

  logic [COL_W-1:0] column_count;
  logic             first_row;
  logic [COL_W-1:0] cc;
  logic [COL_W-1:0] col;
  logic             last;
  logic             fr;

  always_comb begin
    cc      = frame_start ? '0 : column_count;
    col     = (cc >= last_col) ? last_col : cc;
    last    = (col == last_col);
    fr      = frame_start | first_row;
    rd_addr = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
      pix.valid    <= 1'b0;
    end else begin
      pix.valid <= accept;
      if (accept) begin
        column_count <= last ? '0 : col + COL_W'(1);
        first_row    <= last ? 1'b0 : fr;
      end
    end
    if (accept) begin
      pix.col         <= col;
      pix.last        <= last;
      pix.first_row   <= fr;
      pix.frame_start <= frame_start;
      pix.gray        <= gray;
    end
  end

endmodule

@@ rtl/core/edh_diffuse.sv @@
module edh_diffuse
  import edh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  pix_t             pix,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  err_t             rd_data,
  output wr_t              wr,
  output logic             res_valid,
  output logic             res_bit
);

  err_t right_error;
  err_t pend_bl;
  err_t pend_b;
  wr_t  dfr;
  logic fwd_hit;
  err_t fwd_data;

  err_t               re;
  err_t               pbl;
  err_t               pb;
  err_t               mem_above;
  err_t               above;
  logic signed [12:0] v;
  logic signed [12:0] e13;
  logic signed [11:0] e;
  logic signed [15:0] ex;
  logic signed [11:0] s7;
  logic signed [11:0] s3;
  logic signed [11:0] s5;
  logic signed [11:0] s1;
  err_t               sum3;
  err_t               below_here;
  logic               bit_w;

  always_comb begin
    re  = pix.frame_start ? '0 : right_error;
    pbl = pix.frame_start ? '0 : pend_bl;
    pb  = pix.frame_start ? '0 : pend_b;

    // newest write to the entry wins
    priority if (dfr.en && dfr.addr == pix.col) begin
      mem_above = dfr.data;
    end else if (fwd_hit) begin
      mem_above = fwd_data;
    end else begin
      mem_above = rd_data;
    end
    above = pix.first_row ? '0 : mem_above;

    v = $signed({5'b0, pix.gray}) + $signed({{2{above[10]}}, above})
        + $signed({{2{re[10]}}, re});
    bit_w = (v >= 13'sd128);
    e13   = bit_w ? v - 13'sd255 : v;
    e     = e13[11:0];
    ex    = {{4{e[11]}}, e};
    s7    = div16((ex <<< 3) - ex);
    s3    = div16((ex <<< 1) + ex);
    s5    = div16((ex <<< 2) + ex);
    s1    = div16(ex);

    sum3       = sat11($signed({{2{pbl[10]}}, pbl}) + $signed({s3[11], s3}));
    below_here = sat11($signed({{2{pb[10]}}, pb}) + $signed({s5[11], s5}));

    // a deferred write never meets a below-left write: it is followed by column 0
    if (dfr.en) begin
      wr = dfr;
    end else begin
      wr.en   = pix.valid && (pix.col != '0);
      wr.addr = pix.col - COL_W'(1);
      wr.data = sum3;
    end

    res_valid = pix.valid;
    res_bit   = bit_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_error <= '0;
      pend_bl     <= '0;
      pend_b      <= '0;
      dfr.en      <= 1'b0;
      fwd_hit     <= 1'b0;
    end else begin
      dfr.en  <= pix.valid && pix.last;
      fwd_hit <= wr.en && rd_en && (wr.addr == rd_addr);
      if (pix.valid) begin
        if (pix.last) begin
          right_error <= '0;
          pend_bl     <= '0;
          pend_b      <= '0;
        end else begin
          right_error <= sat11({s7[11], s7});
          pend_bl     <= below_here;
          pend_b      <= sat11({s1[11], s1});
        end
      end
    end
    dfr.addr <= pix.col;
    dfr.data <= below_here;
    fwd_data <= wr.data;
  end

endmodule

@@ rtl/core/edh_out_queue.sv @@
module edh_out_queue
  import edh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                din,
  input  logic                pop,
  output logic                valid,
  output logic                dout,
  output logic [OQ_CNT_W-1:0] count
);

  logic                q      [OQ_DEPTH];
  logic                q_next [OQ_DEPTH];
  logic [OQ_CNT_W-1:0] idx;

  always_comb begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < OQ_DEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    idx = count - OQ_CNT_W'(pop);
    if (push) begin
      q_next[idx] = din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign valid = (count != '0);
  assign dout  = q[0];

endmodule

@@ rtl/core/error_diffusion_halftone_unit.sv @@
// channel   direction  payload (low bit first)           accepted when
// s_axis    in         tdata: gray_in[7:0]; tuser: frame  tvalid && tready
//                      _start
// m_axis    out        tdata: dither_bit, zero pad        tvalid && tready
// cfg       in         data: line_width[10:0]             valid && ready
//
// one pixel per clock while m_axis keeps up; a pixel and its line buffer read
// are registered; the result, from the error loop through right_error, is queued
// the line buffer has one write port: a row's last pixel posts its second
// entry in the next cycle, with forwarding for the following reads
// rst is synchronous; the line buffer needs no clearing pass after reset
// a three-entry output queue absorbs m_axis stalls; s_axis stalls once the
// queue and the pixel in flight together hold three results
module error_diffusion_halftone_unit
  import edh_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // gray_in[7:0]
  input  logic            s_axis_tuser,   // frame_start
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // dither_bit, then zeros
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [LW_W-1:0] cfg_data        // line_width
);

  localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_WIDTH);

  logic [LW_W-1:0]     line_width;
  logic [EXT_W-1:0]    lw_ext;
  logic [EXT_W-1:0]    w_eff;
  logic [EXT_W-1:0]    w_m1;
  logic [COL_W-1:0]    last_col;
  logic                s_accept;
  logic                pop;
  logic [COL_W-1:0]    rd_addr;
  err_t                rd_data;
  pix_t                pix;
  wr_t                 wr;
  logic                res_valid;
  logic                res_bit;
  logic                out_bit;
  logic [OQ_CNT_W-1:0] oq_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_width <= cfg_data;
    end
  end

  always_comb begin
    lw_ext = EXT_W'(line_width);
    if (lw_ext == '0) begin
      w_eff = EXT_W'(1);
    end else if (lw_ext > MAX_EXT) begin
      w_eff = MAX_EXT;
    end else begin
      w_eff = lw_ext;
    end
    w_m1     = w_eff - EXT_W'(1);
    last_col = w_m1[COL_W-1:0];
  end

  assign s_axis_tready = (3'(oq_count) + 3'(pix.valid)) < 3'(OQ_DEPTH);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {7'b0, out_bit};

  edh_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (s_accept),
    .gray        (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .last_col    (last_col),
    .rd_addr     (rd_addr),
    .pix         (pix)
  );

  edh_line_buffer u_line_buffer (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (s_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  edh_diffuse u_diffuse (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .rd_en     (s_accept),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .res_valid (res_valid),
    .res_bit   (res_bit)
  );

  edh_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res_bit),
    .pop   (pop),
    .valid (m_axis_tvalid),
    .dout  (out_bit),
    .count (oq_count)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && oq_count == OQ_CNT_W'(OQ_DEPTH) && !pop))
    else $error("output queue overflow");

  a_in_flight: assert property (@(posedge clk) disable iff (rst)
    (3'(oq_count) + 3'(pix.valid)) <= 3'(OQ_DEPTH))
    else $error("too many pixels in flight");

  a_frame_first_row: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_axis_tuser |=> pix.valid && pix.first_row && pix.col == '0)
    else $error("frame start did not restart the scan");

  a_tail_write: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.last |=> wr.en && wr.addr == $past(pix.col))
    else $error("last column entry not written back");

endmodule
